/* rtl/core/sbwu_pkg.sv */
// ----------------------------------------------------------------------------
// sbwu_pkg
// Types and constants shared by the split bf16 weight update core.
// ----------------------------------------------------------------------------
package sbwu_pkg;

   typedef struct packed {
      logic [15:0] weight_upper_half;
      logic [15:0] weight_lower_half;
      logic [15:0] gradient;
      logic        last_in;
   } sbwu_req_type;

   typedef struct packed {
      logic [15:0] new_upper_half;
      logic [15:0] new_lower_half;
      logic        last_out;
   } sbwu_rsp_type;

   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [31:0] POS_INF   = 32'h7F80_0000;

   // Number of register stages in the datapath.
   localparam int NUM_STAGES = 6;

endpackage

/* rtl/core/split_bf16_weight_update_core.sv */
// ----------------------------------------------------------------------------
// split_bf16_weight_update_core
// SGD step on a weight split into two 16-bit halves: w + rate * grad.
//
// Usage: a request carries both weight halves, a bfloat16 gradient and a
// last flag; it is taken when req_valid is high and req_stall is low. The
// result leaves on rsp_valid / rsp_data and is taken when rsp_stall is low.
// The learning rate (binary32) is written through csr_wr_en / csr_wr_data;
// the user must write it only while the core is idle, which the core does
// not enforce; reset sets it to +0.0. Throughput is one request per cycle
// while the receiver does not stall, set by the six-stage pipeline: unpack,
// multiply, round product, align, add, normalize/round. Product and sum
// each round to nearest-even, subnormals kept, a NaN result is 0x7FC00000.
// When the receiver stalls, a full stage holds only if every later stage
// is full too, so req_stall follows rsp_stall whenever the pipe is full;
// bubbles are squeezed out. Reset clears all valid bits.
// ----------------------------------------------------------------------------
module split_bf16_weight_update_core
   import sbwu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  sbwu_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output sbwu_rsp_type rsp_data,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data
);

   logic [31:0] rate_ff;
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= '0;
      end else if (csr_wr_en) begin
         rate_ff <= csr_wr_data;
      end
   end

   // stage i advances when downstream empty or moving
   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES-2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end
   assign req_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_valid;
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (adv[i]) vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // ---------------- stage 1: unpack ----------------
   logic [31:0] w1_ff;
   logic        l1_ff;
   logic        ps1_ff;       // product sign
   logic        pnan1_ff, pinf1_ff, pzero1_ff;
   logic [23:0] ma1_ff;
   logic [7:0]  mb1_ff;
   logic signed [10:0] pe1_ff;  // biased product exponent (unnormalized)
   logic        ps1_in, pnan1_in, pinf1_in, pzero1_in;
   logic [23:0] ma1_in;
   logic [7:0]  mb1_in;
   logic signed [10:0] pe1_in;

   always_comb begin
      logic [7:0] ea, eb;
      logic [22:0] fa;
      logic [6:0] fb;
      logic a_nan, b_nan, a_inf, b_inf, a_z, b_z;
      ea = rate_ff[30:23];
      fa = rate_ff[22:0];
      eb = req_data.gradient[14:7];
      fb = req_data.gradient[6:0];
      a_nan = (ea == 8'hFF) && (fa != '0);
      b_nan = (eb == 8'hFF) && (fb != '0);
      a_inf = (ea == 8'hFF) && (fa == '0);
      b_inf = (eb == 8'hFF) && (fb == '0);
      a_z   = (ea == 8'h00) && (fa == '0);
      b_z   = (eb == 8'h00) && (fb == '0);
      ps1_in   = rate_ff[31] ^ req_data.gradient[15];
      pnan1_in = a_nan || b_nan || (a_inf && b_z) || (b_inf && a_z);
      pinf1_in = (a_inf || b_inf) && !pnan1_in;
      pzero1_in = a_z || b_z;
      ma1_in = {(ea != 8'h00), fa};
      mb1_in = {(eb != 8'h00), fb};
      // value = ma*mb * 2^(pe - 127 - 30)
      pe1_in = 11'(signed'({3'b000, ea})) + 11'(signed'({3'b000, eb}))
               + ((ea == 8'h00) ? 11'sd1 : 11'sd0)
               + ((eb == 8'h00) ? 11'sd1 : 11'sd0) - 11'sd127;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         w1_ff     <= {req_data.weight_upper_half, req_data.weight_lower_half};
         l1_ff     <= req_data.last_in;
         ps1_ff    <= ps1_in;
         pnan1_ff  <= pnan1_in;
         pinf1_ff  <= pinf1_in;
         pzero1_ff <= pzero1_in;
         ma1_ff    <= ma1_in;
         mb1_ff    <= mb1_in;
         pe1_ff    <= pe1_in;
      end
   end

   // ---------------- stage 2: multiply ----------------
   logic [31:0] w2_ff;
   logic        l2_ff, ps2_ff, pnan2_ff, pinf2_ff, pzero2_ff;
   logic [31:0] pm2_ff;
   logic signed [10:0] pe2_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         w2_ff     <= w1_ff;
         l2_ff     <= l1_ff;
         ps2_ff    <= ps1_ff;
         pnan2_ff  <= pnan1_ff;
         pinf2_ff  <= pinf1_ff;
         pzero2_ff <= pzero1_ff;
         pm2_ff    <= ma1_ff * mb1_ff;
         pe2_ff    <= pe1_ff;
      end
   end

   // ---------------- stage 3: round product to binary32 ----------------
   // Normalize the 32-bit product with leading-one shift, then round.
   logic [31:0] w3_ff, p3_ff;
   logic        l3_ff;
   logic [31:0] p3_in;

   function automatic logic [5:0] lzc32(input logic [31:0] v);
      logic [5:0] n;
      n = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) n = 6'(31 - i);
      end
      return n;
   endfunction

   // Round a value m (normalized, bit 31 = leading one when normal) with
   // biased exponent e (of bit 31) and sticky s into binary32.
   function automatic logic [31:0] round32(input logic sgn, input logic [31:0] m,
                                           input logic signed [11:0] e,
                                           input logic s);
      logic [31:0] sh;
      logic        st;
      logic [23:0] mant;
      logic        g, rb;
      logic [24:0] r;
      logic [8:0]  ex;
      logic [5:0]  amt;
      sh = m;
      st = s;
      ex = '0;
      amt = '0;
      if (e >= 12'sd1) begin
         ex = 9'(e);
      end else begin
         // subnormal: shift right by 1 - e
         if ((12'sd1 - e) > 12'sd31) amt = 6'd32;
         else amt = 6'(12'sd1 - e);
         if (amt >= 6'd32) begin
            st = st | (m != '0);
            sh = '0;
         end else begin
            st = st | ((m & ((32'd1 << amt) - 32'd1)) != '0);
            sh = m >> amt;
         end
         ex = 9'd0;
      end
      mant = sh[31:8];
      g    = sh[7];
      st   = st | (sh[6:0] != '0);
      rb   = g && (st || mant[0]);
      r    = {1'b0, mant} + 25'(rb);
      if (r[24]) begin
         ex = ex + 9'd1;
         r = r >> 1;
      end else if (ex == 9'd0 && r[23]) begin
         ex = 9'd1;
      end
      if (ex >= 9'd255) return {sgn, POS_INF[30:0]};
      return {sgn, ex[7:0], r[22:0]};
   endfunction

   always_comb begin
      logic [5:0] lz;
      logic [31:0] nm;
      logic signed [11:0] e;
      lz = lzc32(pm2_ff);
      nm = pm2_ff << lz[4:0];
      // bit 31 of nm weighs 2^(pe-127+1-lz)
      e  = 12'(pe2_ff) + 12'sd1 - 12'(signed'({6'd0, lz}));
      if (pnan2_ff) p3_in = CANON_NAN;
      else if (pinf2_ff) p3_in = {ps2_ff, POS_INF[30:0]};
      else if (pzero2_ff || pm2_ff == '0) p3_in = {ps2_ff, 31'd0};
      else p3_in = round32(ps2_ff, nm, e, 1'b0);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         w3_ff <= w2_ff;
         l3_ff <= l2_ff;
         p3_ff <= p3_in;
      end
   end

   // ---------------- stage 4: classify and align ----------------
   logic        l4_ff, spec4_ff, sl4_ff, sub4_ff, zero4_ff;
   logic [31:0] spv4_ff;
   logic [7:0]  el4_ff;
   logic [27:0] ml4_ff, ms4_ff;   // 24 bits + guard, round, sticky + spare
   logic        spec4_in, sl4_in, sub4_in, zero4_in;
   logic [31:0] spv4_in;
   logic [7:0]  el4_in;
   logic [27:0] ml4_in, ms4_in;

   always_comb begin
      logic [7:0] ex, ey, ea, eb;
      logic [23:0] mx, my;
      logic x_nan, y_nan, x_inf, y_inf, swap;
      logic [31:0] a, b;
      logic [7:0] d;
      logic [27:0] full, sh;
      ex = w3_ff[30:23];
      ey = p3_ff[30:23];
      x_nan = (ex == 8'hFF) && (w3_ff[22:0] != '0);
      y_nan = (ey == 8'hFF) && (p3_ff[22:0] != '0);
      x_inf = (ex == 8'hFF) && !x_nan;
      y_inf = (ey == 8'hFF) && !y_nan;
      spec4_in = 1'b1;
      spv4_in  = CANON_NAN;
      if (x_nan || y_nan || (x_inf && y_inf && (w3_ff[31] != p3_ff[31]))) begin
         spv4_in = CANON_NAN;
      end else if (x_inf) begin
         spv4_in = w3_ff;
      end else if (y_inf) begin
         spv4_in = p3_ff;
      end else begin
         spec4_in = 1'b0;
      end
      swap = w3_ff[30:0] < p3_ff[30:0];
      a = swap ? p3_ff : w3_ff;
      b = swap ? w3_ff : p3_ff;
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      mx = {(a[30:23] != 8'd0), a[22:0]};
      my = {(b[30:23] != 8'd0), b[22:0]};
      d = ea - eb;
      full = {1'b0, my, 3'b000};
      if (d >= 8'd27) begin
         sh = {27'd0, (my != '0)};
      end else begin
         sh = full >> d[4:0];
         sh[0] = sh[0] | ((full & ((28'd1 << d[4:0]) - 28'd1)) != '0);
      end
      sl4_in = a[31];
      sub4_in = a[31] ^ b[31];
      // exact zero sum: sign +0 unless both negative
      zero4_in = (a[30:0] == b[30:0]) && sub4_in;
      el4_in = ea;
      ml4_in = {1'b0, mx, 3'b000};
      ms4_in = sh;
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         l4_ff    <= l3_ff;
         spec4_ff <= spec4_in;
         spv4_ff  <= spv4_in;
         sl4_ff   <= sl4_in;
         sub4_ff  <= sub4_in;
         zero4_ff <= zero4_in;
         el4_ff   <= el4_in;
         ml4_ff   <= ml4_in;
         ms4_ff   <= ms4_in;
      end
   end

   // ---------------- stage 5: add ----------------
   logic        l5_ff, spec5_ff, s5_ff, zero5_ff;
   logic [31:0] spv5_ff;
   logic [7:0]  e5_ff;
   logic [27:0] m5_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         l5_ff    <= l4_ff;
         spec5_ff <= spec4_ff;
         spv5_ff  <= spv4_ff;
         s5_ff    <= sl4_ff;
         zero5_ff <= zero4_ff;
         e5_ff    <= el4_ff;
         m5_ff    <= sub4_ff ? (ml4_ff - ms4_ff) : (ml4_ff + ms4_ff);
      end
   end

   // ---------------- stage 6: normalize and round ----------------
   sbwu_rsp_type rsp6_ff;
   logic [31:0]  r6_in;

   always_comb begin
      logic [5:0] lz;
      logic [31:0] m32, nm;
      logic signed [11:0] e;
      m32 = {m5_ff, 4'd0};
      lz = lzc32(m32);
      nm = m32 << lz[4:0];
      // bit 26 of m5 weighs 2^(e5-127): bit 31 of m32 weighs 2^(e5-127+1)
      e = 12'(signed'({4'd0, e5_ff})) + 12'sd1 - 12'(signed'({6'd0, lz}));
      if (spec5_ff) r6_in = spv5_ff;
      else if (zero5_ff) r6_in = 32'd0;
      // two zeros of the same sign keep that sign
      else if (m5_ff == '0) r6_in = {s5_ff, 31'd0};
      else r6_in = round32(s5_ff, nm, e, 1'b0);
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         rsp6_ff.new_upper_half <= r6_in[31:16];
         rsp6_ff.new_lower_half <= r6_in[15:0];
         rsp6_ff.last_out       <= l5_ff;
      end
   end

   assign rsp_valid = vld_ff[NUM_STAGES-1];
   assign rsp_data  = rsp6_ff;

   // ---------------- assertions ----------------
   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while output free");

   a_hold_output: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   a_nan_canonical: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.new_upper_half[14:7] == 8'hFF
       && (rsp_data.new_upper_half[6:0] != 7'd0 || rsp_data.new_lower_half != 16'd0))
      |-> (rsp_data.new_upper_half == CANON_NAN[31:16]
           && rsp_data.new_lower_half == CANON_NAN[15:0]))
      else $error("non-canonical NaN");

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for split_bf16_weight_update_core. A bit-exact software float
// model (separate product and sum roundings to nearest-even, subnormals
// kept, canonical NaN) predicts every updated weight. Directed corners,
// extreme learning rates, random streams and a long receiver hold-off are
// run with random idling on both channels, except while no_idle is set.
// ----------------------------------------------------------------------------
module tb;
   import sbwu_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   sbwu_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   sbwu_rsp_type rsp_data;
   logic         csr_wr_en = 1'b0;
   logic [31:0]  csr_wr_data = '0;

   logic [31:0]  learn_rate = 32'h0;
   sbwu_rsp_type pending_weights[$];
   int           errors = 0;
   int           quiet_cycles = 0;
   bit           no_idle = 1'b0;
   bit           hold_go = 1'b0;
   int           hold_left = 0;

   split_bf16_weight_update_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // value = sign * m * 2^e, rounded to binary32 nearest-even
   function automatic logic [31:0] fp_round(input logic s, input logic [127:0] m,
                                            input int e);
      int           p;
      int           shift;
      int           sh;
      int           ex;
      logic [127:0] q;
      logic [127:0] r;
      logic [127:0] half;
      p = 0;
      for (int i = 127; i >= 0; i--) begin
         if (m[i]) begin
            p = i;
            break;
         end
      end
      shift = p - 23;
      if (shift < -149 - e) shift = -149 - e;
      if (shift > 0) begin
         sh = (shift > 100) ? 100 : shift;
         q = m >> sh;
         r = m & ((128'd1 << sh) - 1);
         half = 128'd1 << (sh - 1);
         if (r > half || (r == half && q[0])) q = q + 1;
      end else begin
         q = m << (-shift);
      end
      ex = e + shift + 150;
      if (q[24]) begin
         q = q >> 1;
         ex++;
      end
      if (!q[23]) ex = 0;
      if (ex >= 255) return {s, POS_INF[30:0]};
      return {s, ex[7:0], q[22:0]};
   endfunction

   function automatic void fp_unpack(input logic [31:0] a, output logic [127:0] m,
                                     output int x);
      m = (a[30:23] != 0) ? {104'd0, 1'b1, a[22:0]} : {105'd0, a[22:0]};
      x = (a[30:23] != 0) ? int'(a[30:23]) - 150 : -149;
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic         s;
      logic         a_inf;
      logic         b_inf;
      logic         a_zero;
      logic         b_zero;
      logic [127:0] ma;
      logic [127:0] mb;
      int           xa;
      int           xb;
      s = a[31] ^ b[31];
      a_inf = a[30:0] == POS_INF[30:0];
      b_inf = b[30:0] == POS_INF[30:0];
      a_zero = a[30:0] == 0;
      b_zero = b[30:0] == 0;
      if (a[30:0] > POS_INF[30:0] || b[30:0] > POS_INF[30:0]) return CANON_NAN;
      if ((a_inf && b_zero) || (b_inf && a_zero)) return CANON_NAN;
      if (a_inf || b_inf) return {s, POS_INF[30:0]};
      if (a_zero || b_zero) return {s, 31'd0};
      fp_unpack(a, ma, xa);
      fp_unpack(b, mb, xb);
      return fp_round(s, ma * mb, xa + xb);
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0]  big;
      logic [31:0]  lit;
      logic [127:0] mbig;
      logic [127:0] mlit;
      logic [127:0] mag;
      int           xbig;
      int           xlit;
      int           diff;
      int           d;
      int           rest;
      logic         s;
      if (a[30:0] > POS_INF[30:0] || b[30:0] > POS_INF[30:0]) return CANON_NAN;
      if (a[30:0] == POS_INF[30:0] && b[30:0] == POS_INF[30:0] && a[31] != b[31])
         return CANON_NAN;
      if (a[30:0] == POS_INF[30:0]) return a;
      if (b[30:0] == POS_INF[30:0]) return b;
      if (a[30:23] >= b[30:23]) begin
         big = a;
         lit = b;
      end else begin
         big = b;
         lit = a;
      end
      fp_unpack(big, mbig, xbig);
      fp_unpack(lit, mlit, xlit);
      // shift the larger operand up; whatever the smaller loses past 40 bits
      // only matters as a sticky bit
      diff = xbig - xlit;
      d = (diff > 40) ? 40 : diff;
      mbig = mbig << d;
      rest = diff - d;
      if (rest >= 64) mlit = {127'd0, mlit != 0};
      else if (rest > 0)
         mlit = (mlit >> rest) | {127'd0, (mlit & ((128'd1 << rest) - 1)) != 0};
      if (big[31] == lit[31]) begin
         mag = mbig + mlit;
         s = big[31];
      end else if (mbig >= mlit) begin
         mag = mbig - mlit;
         s = big[31];
      end else begin
         mag = mlit - mbig;
         s = lit[31];
      end
      if (mag == 0) return {a[31] & b[31], 31'd0};
      return fp_round(s, mag, xlit + rest);
   endfunction

   function automatic sbwu_rsp_type predict_weight(input sbwu_req_type rq);
      sbwu_rsp_type rs;
      logic [31:0]  w;
      w = fp_add({rq.weight_upper_half, rq.weight_lower_half},
                 fp_mul(learn_rate, {rq.gradient, 16'd0}));
      rs.new_upper_half = w[31:16];
      rs.new_lower_half = w[15:0];
      rs.last_out = rq.last_in;
      return rs;
   endfunction

   // called at a rising edge; returns at the edge that accepts the request
   task automatic send_request(input logic [31:0] w, input logic [15:0] g,
                               input logic last);
      sbwu_req_type rq;
      if (!no_idle && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      rq.weight_upper_half = w[31:16];
      rq.weight_lower_half = w[15:0];
      rq.gradient = g;
      rq.last_in = last;
      req_data <= rq;
      req_valid <= 1'b1;
      do @(negedge clock); while (req_stall);
      pending_weights.push_back(predict_weight(rq));
      @(posedge clock);
   endtask

   task automatic write_rate(input logic [31:0] v);
      req_valid <= 1'b0;
      while (pending_weights.size() != 0) @(posedge clock);
      repeat (NUM_STAGES + 2) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      learn_rate = v;
   endtask

   function automatic logic [31:0] rand_weight(input logic [15:0] g);
      int ex;
      logic [31:0] w;
      w = $urandom;
      // in three cases of four, put the weight near rate * grad so the sum really rounds
      if ($urandom_range(0, 3) != 0) begin
         ex = int'(g[14:7]) + int'(learn_rate[30:23]) - 127 + $urandom_range(0, 20) - 10;
         if (ex < 0) ex = 0;
         if (ex > 254) ex = 254;
         w[30:23] = ex[7:0];
      end
      return w;
   endfunction

   task automatic send_random(input int n);
      logic [15:0] g;
      for (int i = 0; i < n; i++) begin
         g = 16'($urandom);
         if ($urandom_range(0, 9) != 0) g[14:7] = 8'($urandom_range(100, 150));
         if ($urandom_range(0, 19) == 0)
            send_request($urandom_range(0, 1) ? 32'h7F80_0000 : 32'h0000_0001, g,
                         1'($urandom_range(0, 1)));
         else
            send_request(rand_weight(g), g, 1'($urandom_range(0, 1)));
      end
   endtask

   // rate at reset is +0.0: with a finite gradient the product is zero and finite nonzero weights come back unchanged
   task automatic test_reset_rate();
      send_request(32'h3F80_0000, 16'h3F80, 1'b0);
      send_request(32'h8000_0000, 16'h8000, 1'b1);
      send_request(32'h7FC0_0001, 16'h3F80, 1'b0);
      send_request(32'h7F80_0000, 16'h7F80, 1'b0);
      send_random(8);
   endtask

   task automatic test_corners();
      logic [31:0] wl[10] = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000,
                              32'h7F7F_FFFF, 32'h7F80_0000, 32'hFF80_0000,
                              32'h7FC0_0001, 32'h0000_0001, 32'hFFFF_FFFF,
                              32'h0080_0000};
      logic [15:0] gl[10] = '{16'h0000, 16'h8000, 16'hBF80, 16'h7F7F, 16'h7F80,
                              16'h7F80, 16'h3F80, 16'h8000, 16'hFFFF, 16'h8001};
      write_rate(32'h3F80_0000);
      for (int i = 0; i < 10; i++) send_request(wl[i], gl[i], i[0]);
      // negative rate: exact cancellations, also of subnormals, an overflow and an infinite product
      write_rate(32'hBF80_0000);
      send_request(32'h3F80_0000, 16'h3F80, 1'b1);
      send_request(32'h0080_0000, 16'h0080, 1'b0);
      send_request(32'h0001_0000, 16'h0001, 1'b0);
      send_request(32'hFF7F_FFFF, 16'h7F7F, 1'b1);
      send_request(32'h0000_0000, 16'hFF80, 1'b0);
   endtask

   task automatic test_rate_extremes();
      logic [31:0] rl[7] = '{32'hFFFF_FFFF, 32'h7F80_0000, 32'h0000_0001,
                             32'h7F7F_FFFF, 32'h8000_0000, 32'hFF80_0000,
                             32'h0000_0000};
      foreach (rl[i]) begin
         write_rate(rl[i]);
         send_request(32'h3F80_0000, 16'h0000, 1'b0);
         send_random(10);
      end
   endtask

   task automatic test_random_rates();
      for (int k = 0; k < 5; k++) begin
         if (k == 0) write_rate(32'h3C23_D70A);
         else write_rate({$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'($urandom_range(90, 160)),
                          23'($urandom)});
         no_idle = (k == 2);
         send_random(80);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_backpressure();
      write_rate(32'h3DCC_CCCD);
      hold_go = 1'b1;
      no_idle = 1'b1;
      send_random(40);
      no_idle = 1'b0;
      send_random(20);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_rate();
      test_corners();
      test_rate_extremes();
      test_random_rates();
      test_backpressure();
      req_valid <= 1'b0;
      while (pending_weights.size() != 0) @(posedge clock);
      repeat (NUM_STAGES + 4) @(posedge clock);
      if (errors == 0) $display("split_bf16_weight_update_core: match");
      else $display("split_bf16_weight_update_core: mismatch");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_go) begin
         hold_go = 1'b0;
         hold_left = 200;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(0, 99) < 15);
      end
   end

   always @(posedge clock) begin
      sbwu_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_weights.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            errors++;
         end else begin
            want = pending_weights.pop_front();
            if (rsp_data.new_upper_half !== want.new_upper_half ||
                rsp_data.new_lower_half !== want.new_lower_half ||
                rsp_data.last_out !== want.last_out) begin
               $display("%0t: expected %h_%h last %b, got %h_%h last %b", $time,
                        want.new_upper_half, want.new_lower_half, want.last_out,
                        rsp_data.new_upper_half, rsp_data.new_lower_half,
                        rsp_data.last_out);
               errors++;
            end
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 2000) begin
         $display("split_bf16_weight_update_core: mismatch");
         $finish;
      end
   end

endmodule

/* sim.f */
rtl/core/sbwu_pkg.sv
rtl/core/split_bf16_weight_update_core.sv
test/tb.sv
